FILE: rtl/sjfk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjfk_pkg
// Shared types, widths, latencies and series constants of the six-joint
// forward kinematics core.
// ----------------------------------------------------------------------------
package sjfk_pkg;

    localparam int TRIG_FRAC_BITS = 15;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
    localparam int ROT_W          = TRIG_FRAC_BITS + 3;
    localparam int ANGLE_W        = 16;
    localparam int LEN_W          = 16;
    localparam int POS_W          = LEN_W + ROT_W + 3;
    localparam int COORD_W        = 20;
    localparam int IDX_W          = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int NUM_JOINTS     = 6;
    localparam int NUM_POINTS     = 7;
    localparam int S_TDATA_W      = NUM_JOINTS * ANGLE_W;
    localparam int M_TDATA_W      = 64;

    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NUM_POINTS - 1);
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(256);

    // joints two, three and five turn about y, the others about z
    localparam logic [NUM_JOINTS-1:0] JOINT_AXIS_Y = 6'b010110;

    // series arithmetic, Q30
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [30:0] PI_Q29  = 31'd1686629713;
    localparam int          RND_SH  = 30 - TRIG_FRAC_BITS;
    localparam int          STEP_LAT  = 3;
    localparam int          SIN_STEPS = 6;
    localparam int          COS_STEPS = 7;
    localparam int          SC_LAT    = 2 + COS_STEPS * STEP_LAT + 1;
    localparam int          CELL_LAT  = 4;
    localparam int          TOTAL_LAT = SC_LAT + CELL_LAT * NUM_JOINTS;

    localparam logic [63:0] TWO_32 = 64'd4294967296;

    localparam logic [7:0] SIN_DIV [SIN_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] COS_DIV [COS_STEPS] =
        '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

    localparam logic [31:0] SIN_RECIP [SIN_STEPS] = '{
        32'(TWO_32 / 64'd156), 32'(TWO_32 / 64'd110), 32'(TWO_32 / 64'd72),
        32'(TWO_32 / 64'd42),  32'(TWO_32 / 64'd20),  32'(TWO_32 / 64'd6)};
    localparam logic [31:0] COS_RECIP [COS_STEPS] = '{
        32'(TWO_32 / 64'd182), 32'(TWO_32 / 64'd132), 32'(TWO_32 / 64'd90),
        32'(TWO_32 / 64'd56),  32'(TWO_32 / 64'd30),  32'(TWO_32 / 64'd12),
        32'(TWO_32 / 64'd2)};

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINK_ONE,
        REG_LINK_TWO,
        REG_LINK_THREE,
        REG_LINK_FOUR,
        REG_LINK_FIVE,
        REG_LINK_SIX
    } cfg_reg_t;

    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [ROT_W-1:0]  rot_t;
    typedef rot_t     [2:0]           rot_row_t;
    typedef rot_row_t [2:0]           rot_mat_t;
    typedef logic signed [POS_W-1:0]  pos_t;
    typedef pos_t     [2:0]           vec_t;

    typedef struct packed {
        trig_t sn;
        trig_t cs;
    } sc_t;

endpackage

FILE: rtl/sjfk_series_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjfk_series_step
// One Horner step of the sine or cosine series: t' = 1 - (x2*t)/(k*(k-1)),
// clamped at zero. Three register stages; constant division by reciprocal.
// ----------------------------------------------------------------------------
module sjfk_series_step (
    input  logic        aclk,
    input  logic        en,
    input  logic [7:0]  div_val,
    input  logic [31:0] div_recip,
    input  logic [31:0] x2_in,
    input  logic [30:0] t_in,
    output logic [30:0] t_out
);
    import sjfk_pkg::*;

    logic [62:0] prod_a;
    logic [63:0] prod_b;
    logic [39:0] qd;
    logic [39:0] rem;
    logic [31:0] q;
    logic [31:0] p_reg, p_next;
    logic [31:0] p_d_reg;
    logic [31:0] q0_reg, q0_next;
    logic [30:0] t_reg, t_next;

    always_comb begin
        prod_a  = {31'b0, x2_in} * {32'b0, t_in};
        p_next  = prod_a[61:30];
        prod_b  = {32'b0, p_reg} * {32'b0, div_recip};
        q0_next = prod_b[63:32];
        // reciprocal estimate is low by at most one
        qd      = {8'b0, q0_reg} * {32'b0, div_val};
        rem     = {8'b0, p_d_reg} - qd;
        q       = (rem >= {32'b0, div_val}) ? q0_reg + 32'd1 : q0_reg;
        t_next  = (q >= {1'b0, Q30_ONE}) ? '0 : Q30_ONE - q[30:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg   <= p_next;
            p_d_reg <= p_reg;
            q0_reg  <= q0_next;
            t_reg   <= t_next;
        end
    end

    assign t_out = t_reg;

endmodule

FILE: rtl/sjfk_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjfk_sincos
// Pipelined sine and cosine of a 16-bit turn fraction.
// ----------------------------------------------------------------------------
module sjfk_sincos (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [sjfk_pkg::ANGLE_W-1:0] angle,
    output sjfk_pkg::sc_t                sc
);
    import sjfk_pkg::*;

    localparam int X2_TAPS = (COS_STEPS - 1) * STEP_LAT;
    localparam int X_TAPS  = SIN_STEPS * STEP_LAT;
    localparam int Q_TAPS  = SC_LAT - 2;
    localparam int S_TAPS  = (COS_STEPS - SIN_STEPS) * STEP_LAT - 1;
    localparam int MAG_W   = TRIG_W - 1;

    quad_t             quad_dly_reg [Q_TAPS+1];
    logic [30:0]       x_reg, x_next;
    logic [30:0]       x_dly_reg [X_TAPS+1];
    logic [31:0]       x2_dly_reg [X2_TAPS+1];
    logic [31:0]       x2_next;
    logic [MAG_W-1:0]  s_dly_reg [S_TAPS+1];
    logic [MAG_W-1:0]  s_next;
    sc_t               sc_reg, sc_next;

    logic [30:0] sin_t [SIN_STEPS+1];
    logic [30:0] cos_t [COS_STEPS+1];

    logic [44:0] prod_x;
    logic [44:0] sum_x;
    logic [61:0] prod_x2;
    logic [61:0] prod_s;
    logic [32:0] sum_s;
    logic [31:0] sum_c;
    logic [MAG_W-1:0] c_mag;
    trig_t       s_pos, c_pos;

    assign sin_t[0] = Q30_ONE;
    assign cos_t[0] = Q30_ONE;

    for (genvar j = 0; j < SIN_STEPS; j++) begin : g_sin
        sjfk_series_step u_step (
            .aclk      (aclk),
            .en        (en),
            .div_val   (SIN_DIV[j]),
            .div_recip (SIN_RECIP[j]),
            .x2_in     (x2_dly_reg[j*STEP_LAT]),
            .t_in      (sin_t[j]),
            .t_out     (sin_t[j+1])
        );
    end

    for (genvar j = 0; j < COS_STEPS; j++) begin : g_cos
        sjfk_series_step u_step (
            .aclk      (aclk),
            .en        (en),
            .div_val   (COS_DIV[j]),
            .div_recip (COS_RECIP[j]),
            .x2_in     (x2_dly_reg[j*STEP_LAT]),
            .t_in      (cos_t[j]),
            .t_out     (cos_t[j+1])
        );
    end

    always_comb begin
        prod_x  = {31'b0, angle[ANGLE_W-3:0]} * {14'b0, PI_Q29};
        sum_x   = prod_x + 45'd8192;
        x_next  = sum_x[44:14];
        prod_x2 = {31'b0, x_reg} * {31'b0, x_reg};
        x2_next = prod_x2[61:30];
        prod_s  = {31'b0, x_dly_reg[X_TAPS]} * {31'b0, sin_t[SIN_STEPS]};
        sum_s   = {1'b0, prod_s[61:30]} + 33'(64'd1 << (RND_SH - 1));
        s_next  = sum_s[RND_SH +: MAG_W];
        sum_c   = {1'b0, cos_t[COS_STEPS]} + 32'(64'd1 << (RND_SH - 1));
        c_mag   = sum_c[RND_SH +: MAG_W];
        s_pos   = trig_t'({1'b0, s_dly_reg[S_TAPS]});
        c_pos   = trig_t'({1'b0, c_mag});
        // fold the first-quadrant pair into the full turn
        case (quad_dly_reg[Q_TAPS])
            QUAD_0: begin
                sc_next.sn = s_pos;
                sc_next.cs = c_pos;
            end
            QUAD_1: begin
                sc_next.sn = c_pos;
                sc_next.cs = -s_pos;
            end
            QUAD_2: begin
                sc_next.sn = -s_pos;
                sc_next.cs = -c_pos;
            end
            default: begin
                sc_next.sn = -c_pos;
                sc_next.cs = s_pos;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quad_dly_reg[0] <= quad_t'(angle[ANGLE_W-1 -: 2]);
            for (int k = 1; k <= Q_TAPS; k++) begin
                quad_dly_reg[k] <= quad_dly_reg[k-1];
            end
            x_reg <= x_next;
            x_dly_reg[0] <= x_reg;
            for (int k = 1; k <= X_TAPS; k++) begin
                x_dly_reg[k] <= x_dly_reg[k-1];
            end
            x2_dly_reg[0] <= x2_next;
            for (int k = 1; k <= X2_TAPS; k++) begin
                x2_dly_reg[k] <= x2_dly_reg[k-1];
            end
            s_dly_reg[0] <= s_next;
            for (int k = 1; k <= S_TAPS; k++) begin
                s_dly_reg[k] <= s_dly_reg[k-1];
            end
            sc_reg <= sc_next;
        end
    end

    assign sc = sc_reg;

endmodule

FILE: rtl/sjfk_joint_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjfk_joint_cell
// One joint of the arm: turn the orientation by the joint angle, then move
// the origin along the new z axis by the link length. Four register stages.
// ----------------------------------------------------------------------------
module sjfk_joint_cell (
    input  logic                       aclk,
    input  logic                       en,
    input  logic                       axis_y,
    input  sjfk_pkg::sc_t              sc,
    input  logic [sjfk_pkg::LEN_W-1:0] link_len,
    input  sjfk_pkg::rot_mat_t         rot_in,
    input  sjfk_pkg::vec_t             pos_in,
    output sjfk_pkg::rot_mat_t         rot_out,
    output sjfk_pkg::vec_t             pos_out
);
    import sjfk_pkg::*;

    localparam int PROD_W = TRIG_W + ROT_W;
    localparam int ADV_W  = LEN_W + 1 + ROT_W;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [PROD_W:0]   psum_t;
    typedef logic signed [ADV_W-1:0]  adv_t;

    localparam psum_t RND_HALF = psum_t'(64'd1 << (TRIG_FRAC_BITS - 1));

    prod_t    ca_reg [3], ca_next [3];
    prod_t    sb_reg [3], sb_next [3];
    prod_t    sa_reg [3], sa_next [3];
    prod_t    cb_reg [3], cb_next [3];
    adv_t     adv_reg [3], adv_next [3];
    rot_mat_t rot_a_reg, rot_b_reg, rot_b_next, rot_c_reg, rot_out_reg;
    vec_t     pos_a_reg, pos_b_reg, pos_c_reg, pos_out_reg, pos_next;
    psum_t    lo_sum [3], hi_sum [3];
    rot_t     a_el [3], b_el [3];

    function automatic rot_t rot_round(input psum_t v);
        psum_t w;
        w = v + RND_HALF;
        return rot_t'(w >>> TRIG_FRAC_BITS);
    endfunction

    always_comb begin
        rot_b_next = rot_a_reg;
        for (int i = 0; i < 3; i++) begin
            a_el[i]    = rot_in[i][0];
            b_el[i]    = axis_y ? rot_in[i][2] : rot_in[i][1];
            ca_next[i] = prod_t'($signed(sc.cs)) * prod_t'($signed(a_el[i]));
            sb_next[i] = prod_t'($signed(sc.sn)) * prod_t'($signed(b_el[i]));
            sa_next[i] = prod_t'($signed(sc.sn)) * prod_t'($signed(a_el[i]));
            cb_next[i] = prod_t'($signed(sc.cs)) * prod_t'($signed(b_el[i]));

            if (axis_y) begin
                lo_sum[i] = psum_t'(ca_reg[i]) - psum_t'(sb_reg[i]);
                hi_sum[i] = psum_t'(sa_reg[i]) + psum_t'(cb_reg[i]);
            end else begin
                lo_sum[i] = psum_t'(ca_reg[i]) + psum_t'(sb_reg[i]);
                hi_sum[i] = psum_t'(cb_reg[i]) - psum_t'(sa_reg[i]);
            end
            rot_b_next[i][0] = rot_round(lo_sum[i]);
            if (axis_y) begin
                rot_b_next[i][2] = rot_round(hi_sum[i]);
            end else begin
                rot_b_next[i][1] = rot_round(hi_sum[i]);
            end

            adv_next[i] = adv_t'($signed({1'b0, link_len})) * adv_t'($signed(rot_b_reg[i][2]));
            pos_next[i] = pos_c_reg[i] + pos_t'(adv_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                ca_reg[i]  <= ca_next[i];
                sb_reg[i]  <= sb_next[i];
                sa_reg[i]  <= sa_next[i];
                cb_reg[i]  <= cb_next[i];
                adv_reg[i] <= adv_next[i];
            end
            rot_a_reg   <= rot_in;
            pos_a_reg   <= pos_in;
            rot_b_reg   <= rot_b_next;
            pos_b_reg   <= pos_a_reg;
            rot_c_reg   <= rot_b_reg;
            pos_c_reg   <= pos_b_reg;
            rot_out_reg <= rot_c_reg;
            pos_out_reg <= pos_next;
        end
    end

    assign rot_out = rot_out_reg;
    assign pos_out = pos_out_reg;

endmodule

FILE: rtl/six_joint_forward_kinematics_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_joint_forward_kinematics_core
// Forward kinematics of a six-joint serial arm, seven points per word.
// ----------------------------------------------------------------------------
// Each input word carries six joint angles; the core answers with seven
// output words, the origin of each joint frame (index 0 to 5) and the tool
// point (index 6, tlast high), as signed Q12.8 coordinates. An item runs
// through a 24-stage sine/cosine pipeline and then a chain of six joint
// cells, four stages each. Items follow each other through the chain, one
// every cycle while the chain is not stalled, but the single result port
// moves one point per cycle while m_tready is high, so each item holds the
// port for its seven points. The user must write link lengths through the
// cfg port only while no item is in flight; the core does not enforce this.
// cfg_ready is always high and an index past the six link registers is ignored.
// ----------------------------------------------------------------------------
module six_joint_forward_kinematics_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // angle_one, angle_two, angle_three, angle_four, angle_five, angle_six
    input  logic [sjfk_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // point_index, pos_x, pos_y, pos_z, zero pad
    output logic [sjfk_pkg::M_TDATA_W-1:0]   m_tdata,
    // last_point
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sjfk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sjfk_pkg::LEN_W-1:0]       cfg_data
);
    import sjfk_pkg::*;

    localparam int LINE_D = CELL_LAT * (NUM_JOINTS - 1);
    localparam int PAD_W  = M_TDATA_W - IDX_W - 3 * COORD_W;
    localparam int V_W    = POS_W + 1 - TRIG_FRAC_BITS;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [V_W-1:0]     cwide_t;

    localparam cwide_t COORD_MAX = cwide_t'((64'd1 << (COORD_W - 1)) - 64'd1);
    localparam cwide_t COORD_MIN = -cwide_t'(64'd1 << (COORD_W - 1));
    localparam logic signed [POS_W:0] POS_HALF =
        (POS_W+1)'(64'd1 << (TRIG_FRAC_BITS - 1));

    logic [LEN_W-1:0]     link_len_reg [NUM_JOINTS];
    logic [LEN_W-1:0]     link_len_next [NUM_JOINTS];
    logic [TOTAL_LAT-1:0] vld_reg;
    logic                 vld_last;
    logic                 en;
    logic                 load;
    logic                 busy_reg, busy_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    vec_t                 pt_hold_reg [NUM_POINTS];
    vec_t                 pt_final [NUM_JOINTS];
    vec_t                 pt_sel;
    coord_t               crd_x, crd_y, crd_z;

    sc_t      sc_head [NUM_JOINTS];
    sc_t      sc_line_reg [1:LINE_D][NUM_JOINTS];
    sc_t      sc_cell [NUM_JOINTS];
    rot_mat_t rot_chain [NUM_JOINTS+1];
    vec_t     pos_chain [NUM_JOINTS+1];
    vec_t     pt_line_reg [1:LINE_D][NUM_JOINTS];
    rot_mat_t rot_ident;

    function automatic coord_t to_coord(input pos_t p);
        logic signed [POS_W:0] w;
        cwide_t                v;
        w = $signed({p[POS_W-1], p}) + POS_HALF;
        v = cwide_t'(w >>> TRIG_FRAC_BITS);
        if (v > COORD_MAX) begin
            return coord_t'(COORD_MAX);
        end else if (v < COORD_MIN) begin
            return coord_t'(COORD_MIN);
        end
        return coord_t'(v);
    endfunction

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_comb begin
        link_len_next = link_len_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_LINK_ONE:   link_len_next[0] = cfg_data;
                REG_LINK_TWO:   link_len_next[1] = cfg_data;
                REG_LINK_THREE: link_len_next[2] = cfg_data;
                REG_LINK_FOUR:  link_len_next[3] = cfg_data;
                REG_LINK_FIVE:  link_len_next[4] = cfg_data;
                REG_LINK_SIX:   link_len_next[5] = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NUM_JOINTS; j++) begin
                link_len_reg[j] <= LEN_RESET;
            end
        end else begin
            link_len_reg <= link_len_next;
        end
    end

    // ---------------- pipeline control ----------------
    assign vld_last = vld_reg[TOTAL_LAT-1];
    assign load     = vld_last && (!busy_reg || (m_tready && idx_reg == IDX_LAST));
    assign en       = !vld_last || load;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], s_tvalid};
        end
    end

    // ---------------- angles ----------------
    for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_trig
        sjfk_sincos u_sincos (
            .aclk  (aclk),
            .en    (en),
            .angle (s_tdata[j*ANGLE_W +: ANGLE_W]),
            .sc    (sc_head[j])
        );
    end

    // hold each joint's sine/cosine until the item reaches its cell
    always_ff @(posedge aclk) begin
        if (en) begin
            sc_line_reg[1] <= sc_head;
            for (int k = 2; k <= LINE_D; k++) begin
                sc_line_reg[k] <= sc_line_reg[k-1];
            end
        end
    end

    // ---------------- joint chain ----------------
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                rot_ident[i][k] = (i == k) ? rot_t'(64'd1 << TRIG_FRAC_BITS) : '0;
            end
        end
    end

    assign rot_chain[0] = rot_ident;
    assign pos_chain[0] = '0;

    for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign sc_cell[j] = sc_head[j];
        end else begin : g_tap
            assign sc_cell[j] = sc_line_reg[CELL_LAT*j][j];
        end

        sjfk_joint_cell u_cell (
            .aclk     (aclk),
            .en       (en),
            .axis_y   (JOINT_AXIS_Y[j]),
            .sc       (sc_cell[j]),
            .link_len (link_len_reg[j]),
            .rot_in   (rot_chain[j]),
            .pos_in   (pos_chain[j]),
            .rot_out  (rot_chain[j+1]),
            .pos_out  (pos_chain[j+1])
        );

        if (j == NUM_JOINTS - 1) begin : g_pt_end
            assign pt_final[j] = pos_chain[j+1];
        end else begin : g_pt_dly
            assign pt_final[j] = pt_line_reg[CELL_LAT*(NUM_JOINTS-1-j)][j];
        end
    end

    // carry earlier points along until the item leaves the last cell
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < NUM_JOINTS; j++) begin
                pt_line_reg[1][j] <= pos_chain[j+1];
            end
            for (int k = 2; k <= LINE_D; k++) begin
                pt_line_reg[k] <= pt_line_reg[k-1];
            end
        end
    end

    // ---------------- result serializer ----------------
    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (busy_reg && m_tready) begin
            if (idx_reg == IDX_LAST) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pt_hold_reg[0] <= '0;
            for (int j = 0; j < NUM_JOINTS; j++) begin
                pt_hold_reg[j+1] <= pt_final[j];
            end
        end
    end

    assign pt_sel   = pt_hold_reg[idx_reg];
    assign crd_x    = to_coord(pt_sel[0]);
    assign crd_y    = to_coord(pt_sel[1]);
    assign crd_z    = to_coord(pt_sel[2]);
    assign m_tvalid = busy_reg;
    assign m_tlast  = (idx_reg == IDX_LAST);
    assign m_tdata  = {{PAD_W{1'b0}}, crd_z, crd_y, crd_x, idx_reg};

    // ---------------- checks ----------------
    a_load_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> busy_reg && idx_reg == '0)
        else $error("serializer did not start at the first point");

    a_idx_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && m_tready && idx_reg != IDX_LAST |=> idx_reg == $past(idx_reg) + IDX_W'(1))
        else $error("point index skipped or repeated");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && m_tready && idx_reg == IDX_LAST && !load |=> !busy_reg)
        else $error("serializer kept a finished item");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_last && !en |=> vld_last)
        else $error("stalled item lost at pipeline end");

    a_origin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && idx_reg == '0 |-> crd_x == '0 && crd_y == '0 && crd_z == '0)
        else $error("base origin is not zero");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the six-joint forward kinematics core.
// ----------------------------------------------------------------------------
// Joint-angle words are streamed into the core, and each of the seven
// position words that come back is checked against a fixed-point model of
// the arm kept in this file. A directed table covers the angle extremes and
// the quadrant boundaries. Random words follow under several link-length
// settings and several idle and stall patterns. One long receiver hold-off
// fills the core and backs up its input.
// ----------------------------------------------------------------------------
module tb;
    import sjfk_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);
    localparam int                   NO_TIP       = -1;

    typedef struct {
        logic [IDX_W-1:0]   idx;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               last;
    } point_t;

    typedef struct {
        logic [NUM_JOINTS-1:0][ANGLE_W-1:0] ang;
        int                                 tip_z;
    } row_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [S_TDATA_W-1:0]        s_tdata;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [M_TDATA_W-1:0]        m_tdata;
    logic                        m_tlast;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [LEN_W-1:0]            cfg_data;

    point_t           points_due[$];
    logic [LEN_W-1:0] arm_len[NUM_JOINTS];
    longint           frame[3][3];
    longint           origin[3];
    int               errors;
    int               send_idle_pct;
    int               recv_stall_pct;
    logic             hold_off;

    six_joint_forward_kinematics_core i_dut (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // arm model
    // ------------------------------------------------------------------------
    function automatic longint rnd_shift(longint v);
        return (v + (64'sd1 <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
    endfunction

    function automatic bit [63:0] taylor_step(bit [63:0] x2, bit [63:0] t, bit [63:0] dv);
        bit [63:0] d;
        d = ((x2 * t) >> 30) / dv;
        return (d >= 64'(Q30_ONE)) ? 64'd0 : 64'(Q30_ONE) - d;
    endfunction

    function automatic void sin_cos_of(logic [ANGLE_W-1:0] a, output longint sn,
                                       output longint cs);
        bit [63:0] r, x, x2, t;
        longint    s, c;
        quad_t     q;
        q  = quad_t'(a[15:14]);
        r  = 64'(a[13:0]);
        x  = (r * 64'(PI_Q29) + 64'd8192) >> 14;
        x2 = (x * x) >> 30;
        t  = 64'(Q30_ONE);
        for (int k = 13; k >= 3; k -= 2) t = taylor_step(x2, t, 64'(k * (k - 1)));
        s = longint'((((x * t) >> 30) + (64'd1 << (RND_SH - 1))) >> RND_SH);
        t = 64'(Q30_ONE);
        for (int k = 14; k >= 2; k -= 2) t = taylor_step(x2, t, 64'(k * (k - 1)));
        c = longint'((t + (64'd1 << (RND_SH - 1))) >> RND_SH);
        case (q)
            QUAD_0: begin sn = s;  cs = c;  end
            QUAD_1: begin sn = c;  cs = -s; end
            QUAD_2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endfunction

    function automatic void turn_frame(logic [ANGLE_W-1:0] a, bit about_y);
        longint sn, cs, u, w;
        sin_cos_of(a, sn, cs);
        for (int i = 0; i < 3; i++) begin
            if (about_y) begin
                u = frame[i][0];
                w = frame[i][2];
                frame[i][0] = rnd_shift(cs * u - sn * w);
                frame[i][2] = rnd_shift(sn * u + cs * w);
            end else begin
                u = frame[i][0];
                w = frame[i][1];
                frame[i][0] = rnd_shift(cs * u + sn * w);
                frame[i][1] = rnd_shift(cs * w - sn * u);
            end
        end
    endfunction

    function automatic logic [COORD_W-1:0] to_coord(longint p);
        longint v;
        v = rnd_shift(p);
        if (v > 524287) v = 524287;
        if (v < -524288) v = -524288;
        return v[COORD_W-1:0];
    endfunction

    function automatic void push_point(int k);
        point_t pt;
        pt.idx  = IDX_W'(k);
        pt.x    = to_coord(origin[0]);
        pt.y    = to_coord(origin[1]);
        pt.z    = to_coord(origin[2]);
        pt.last = (k == NUM_POINTS - 1);
        points_due.push_back(pt);
    endfunction

    function automatic void slide(logic [LEN_W-1:0] len);
        for (int i = 0; i < 3; i++) origin[i] += longint'(len) * frame[i][2];
    endfunction

    function automatic void predict_arm(logic [NUM_JOINTS-1:0][ANGLE_W-1:0] ang);
        for (int i = 0; i < 3; i++) begin
            origin[i] = 0;
            for (int j = 0; j < 3; j++) frame[i][j] = (i == j) ? (1 << TRIG_FRAC_BITS) : 0;
        end
        turn_frame(ang[0], JOINT_AXIS_Y[0]);
        push_point(0);
        for (int i = 1; i < NUM_JOINTS; i++) begin
            slide(arm_len[i-1]);
            push_point(i);
            turn_frame(ang[i], JOINT_AXIS_Y[i]);
        end
        slide(arm_len[NUM_JOINTS-1]);
        push_point(NUM_POINTS - 1);
    endfunction

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        point_t pt;
        if (aresetn && m_tvalid && m_tready) begin
            if (points_due.size() == 0) begin
                report("unexpected word", m_tdata, 0);
            end else begin
                pt = points_due.pop_front();
                if (m_tdata[2:0] !== pt.idx)   report("point_index", m_tdata[2:0], pt.idx);
                if (m_tdata[22:3] !== pt.x)    report("pos_x", m_tdata[22:3], pt.x);
                if (m_tdata[42:23] !== pt.y)   report("pos_y", m_tdata[42:23], pt.y);
                if (m_tdata[62:43] !== pt.z)   report("pos_z", m_tdata[62:43], pt.z);
                if (m_tlast !== pt.last)       report("last_point", m_tlast, pt.last);
            end
        end
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    task automatic send_angles(logic [NUM_JOINTS-1:0][ANGLE_W-1:0] ang);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ang;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_arm(ang);
    endtask

    function automatic logic [ANGLE_W-1:0] rand_angle();
        logic [ANGLE_W-1:0] a;
        a = ANGLE_W'($urandom);
        // bias some angles onto the edges of a quadrant
        if ($urandom_range(3) == 0) a[13:0] = $urandom_range(1) ? 14'h3FFF - 14'($urandom_range(3))
                                                                : 14'($urandom_range(3));
        return a;
    endfunction

    task automatic send_random(int n);
        logic [NUM_JOINTS-1:0][ANGLE_W-1:0] ang;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < NUM_JOINTS; j++) ang[j] = rand_angle();
            send_angles(ang);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (points_due.size() != 0) @(posedge aclk);
        repeat (TOTAL_LAT + 10) @(posedge aclk);
    endtask

    task automatic write_link(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx < NUM_JOINTS) arm_len[idx] = val;
        @(posedge aclk);
    endtask

    task automatic write_all_links(int mode);
        for (int i = 0; i < NUM_JOINTS; i++) begin
            case (mode)
                0: write_link(CFG_IDX_W'(i), '1);
                1: write_link(CFG_IDX_W'(i), '0);
                default: write_link(CFG_IDX_W'(i), LEN_W'($urandom));
            endcase
        end
    endtask

    // angles are listed from joint six down to joint one
    row_t table_rows[] = '{
        '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1536},
        '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, NO_TIP},
        '{'{16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000}, NO_TIP},
        '{'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, NO_TIP},
        '{'{16'hC000, 16'hC000, 16'hC000, 16'hC000, 16'hC000, 16'hC000}, NO_TIP},
        '{'{16'h3FFF, 16'h7FFF, 16'hBFFF, 16'hFFFF, 16'h0001, 16'h4001}, NO_TIP},
        '{'{16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001}, NO_TIP},
        '{'{16'h2000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1536},
        '{'{16'h0000, 16'h2000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, NO_TIP},
        '{'{16'h0000, 16'h0000, 16'h6000, 16'h0000, 16'h0000, 16'h0000}, NO_TIP},
        '{'{16'h0000, 16'h0000, 16'hA000, 16'h0000, 16'h0000, 16'h0000}, 1536},
        '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hE000, 16'h0000}, NO_TIP},
        '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h5555}, 1536},
        '{'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, NO_TIP},
        '{'{16'h1234, 16'hFEDC, 16'h8001, 16'h7FFF, 16'hC001, 16'h3FFE}, NO_TIP}
    };

    initial begin
        errors         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_LINK_ONE;
        cfg_data       = '0;
        for (int i = 0; i < NUM_JOINTS; i++) arm_len[i] = LEN_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words with reset link lengths
        foreach (table_rows[r]) begin
            send_angles(table_rows[r].ang);
            // straight-up tip lies at the sum of the six unit links
            if (table_rows[r].tip_z != NO_TIP)
                points_due[points_due.size()-1].z = COORD_W'(table_rows[r].tip_z);
        end
        drain();

        // spare indexes must leave the links alone
        write_link(REG_SPARE_LO, 16'h1234);
        write_link(REG_SPARE_HI, 16'hFFFF);
        send_random(5);
        drain();

        write_all_links(0);
        send_random(100);
        drain();

        write_all_links(1);
        send_idle_pct = 63;
        send_random(40);
        drain();

        write_all_links(2);
        send_random(60);
        drain();

        write_link(REG_LINK_ONE, 16'h0001);
        write_link(REG_LINK_SIX, 16'hFFFF);
        send_idle_pct  = 0;
        recv_stall_pct = 63;
        send_random(100);
        drain();

        // long hold-off on the result side while words keep coming
        write_all_links(2);
        recv_stall_pct = 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (600) @(posedge aclk);
                hold_off <= 1'b0;
            end
            send_random(60);
        join
        drain();

        write_all_links(2);
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        send_random(70);
        drain();

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
